/* hdl/fp64_dot_product_accumulator_defines.svh */
// ----------------------------------------------------------------------------
// fp64 dot product accumulator: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FP64_DOT_PRODUCT_ACCUMULATOR_DEFINES_SVH
`define FP64_DOT_PRODUCT_ACCUMULATOR_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define FDPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define FDPA_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

/* hdl/fdpa_pkg.sv */
// ----------------------------------------------------------------------------
// fdpa_pkg
// Types, constants and the normalize step shared by the front and back ends.
// ----------------------------------------------------------------------------
package fdpa_pkg;

  localparam int unsigned SIG_W   = 128;
  localparam int unsigned SH_W    = $clog2(SIG_W);
  localparam int unsigned EXP_W   = 14;
  localparam int unsigned TOP_POS = 125;
  localparam int unsigned NORM_STEPS = SH_W;

  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;

  typedef logic signed [EXP_W-1:0] exp_t;
  typedef logic [SIG_W-1:0]        sig_t;

  typedef enum logic [1:0] {
    KIND_FIN,
    KIND_ZERO,
    KIND_INF,
    KIND_NAN
  } kind_e;

  // Exact product: value = sig * 2^exp, sig normalized to TOP_POS when finite.
  typedef struct packed {
    kind_e kind;
    logic  sign;
    exp_t  exp;
    sig_t  sig;
    logic  last;
  } prod_t;

  typedef struct packed {
    sig_t sig;
    exp_t exp;
  } norm_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CNORM,
    B_ALIGN,
    B_ADD,
    B_NORM,
    B_ROUND,
    B_PACK,
    B_DONE
  } back_state_e;

  // One step of a binary leading-zero search: shift left by SIG_W/2 >> idx
  // when that many bits at and below TOP_POS are all clear.
  function automatic norm_t norm_step(sig_t s, exp_t e, logic [SH_W-1:0] idx);
    int unsigned k;
    norm_t       r;
    k = (SIG_W / 2) >> idx;
    if ((s >> (TOP_POS + 1 - k)) == '0) begin
      r.sig = s << k;
      r.exp = e - exp_t'(k);
    end else begin
      r.sig = s;
      r.exp = e;
    end
    return r;
  endfunction

endpackage

/* hdl/fdpa_if.sv */
// ----------------------------------------------------------------------------
// fdpa channel interfaces
// Valid/ready channels for element pairs in and dot products out.
// ----------------------------------------------------------------------------
interface fdpa_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] x_bits;
  logic [63:0] y_bits;
  logic        last;

  modport source (output valid, x_bits, y_bits, last, input ready);
  modport sink   (input valid, x_bits, y_bits, last, output ready);
endinterface

interface fdpa_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] dot_bits;

  modport source (output valid, dot_bits, input ready);
  modport sink   (input valid, dot_bits, output ready);
endinterface

/* hdl/fdpa_front.sv */
// ----------------------------------------------------------------------------
// fdpa_front
// Classify the element pair, form the exact 106-bit product, normalize it.
// ----------------------------------------------------------------------------
module fdpa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  fdpa_in_if.sink           in_chan_i,
  output logic              prod_valid_o,
  input  logic              prod_ready_i,
  output fdpa_pkg::prod_t   prod_o
);

  localparam int unsigned NS = fdpa_pkg::NORM_STEPS;
  // product lsb weight is 2^(ex+ey-2150); the sig is placed 20 bits up
  localparam int PROD_BIAS = 2170;

  typedef struct packed {
    fdpa_pkg::kind_e kind;
    logic            sign;
    fdpa_pkg::exp_t  exp;
    logic            last;
  } meta_t;

  logic advance;

  // stage 0: decode
  logic        v0_q;
  meta_t       m0_q;
  logic [52:0] ma_q, mb_q;

  // stage 1: partial products
  logic        v1_q;
  meta_t       m1_q;
  logic [63:0] pp00_q;
  logic [52:0] pp01_q, pp10_q;
  logic [41:0] pp11_q;

  // stages 2 and up: product, then one normalize step each
  logic [NS:0]     nv_q;
  fdpa_pkg::prod_t np_q [NS+1];

  logic [10:0]     xe, ye, xeu, yeu;
  logic [51:0]     xf, yf;
  logic            xz, yz, xi, yi, xn, yn;
  fdpa_pkg::kind_e kind_c;
  logic [105:0]    prod_c;

  assign advance         = !nv_q[NS] || prod_ready_i;
  assign in_chan_i.ready = advance;
  assign prod_valid_o    = nv_q[NS];
  assign prod_o          = np_q[NS];

  always_comb begin
    xe  = in_chan_i.x_bits[62:52];
    ye  = in_chan_i.y_bits[62:52];
    xf  = in_chan_i.x_bits[51:0];
    yf  = in_chan_i.y_bits[51:0];
    xz  = (xe == '0) && (xf == '0);
    yz  = (ye == '0) && (yf == '0);
    xi  = (xe == '1);
    yi  = (ye == '1);
    xn  = xi && (xf != '0);
    yn  = yi && (yf != '0);
    xeu = (xe == '0) ? 11'd1 : xe;
    yeu = (ye == '0) ? 11'd1 : ye;
    if (xn || yn || (xi && yz) || (xz && yi)) begin
      kind_c = fdpa_pkg::KIND_NAN;
    end else if (xi || yi) begin
      kind_c = fdpa_pkg::KIND_INF;
    end else if (xz || yz) begin
      kind_c = fdpa_pkg::KIND_ZERO;
    end else begin
      kind_c = fdpa_pkg::KIND_FIN;
    end
  end

  always_comb begin
    prod_c = {pp11_q, 64'd0}
           + ({53'd0, pp01_q} << 32)
           + ({53'd0, pp10_q} << 32)
           + {42'd0, pp00_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      nv_q <= '0;
    end else if (advance) begin
      v0_q <= in_chan_i.valid;
      v1_q <= v0_q;
      nv_q <= {nv_q[NS-1:0], v1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m0_q.kind <= kind_c;
      m0_q.sign <= in_chan_i.x_bits[63] ^ in_chan_i.y_bits[63];
      m0_q.exp  <= fdpa_pkg::exp_t'(xeu) + fdpa_pkg::exp_t'(yeu)
                 - fdpa_pkg::exp_t'(PROD_BIAS);
      m0_q.last <= in_chan_i.last;
      ma_q      <= {xe != '0, xf};
      mb_q      <= {ye != '0, yf};

      m1_q   <= m0_q;
      pp00_q <= {32'd0, ma_q[31:0]} * {32'd0, mb_q[31:0]};
      pp01_q <= {21'd0, ma_q[31:0]} * {32'd0, mb_q[52:32]};
      pp10_q <= {32'd0, ma_q[52:32]} * {21'd0, mb_q[31:0]};
      pp11_q <= {21'd0, ma_q[52:32]} * {21'd0, mb_q[52:32]};

      np_q[0].kind <= m1_q.kind;
      np_q[0].sign <= m1_q.sign;
      np_q[0].exp  <= m1_q.exp;
      np_q[0].last <= m1_q.last;
      np_q[0].sig  <= {2'b00, prod_c, 20'd0};

      for (int i = 0; i < NS; i++) begin
        np_q[i+1].kind <= np_q[i].kind;
        np_q[i+1].sign <= np_q[i].sign;
        np_q[i+1].last <= np_q[i].last;
        {np_q[i+1].sig, np_q[i+1].exp} <=
          fdpa_pkg::norm_step(np_q[i].sig, np_q[i].exp, fdpa_pkg::SH_W'(i));
      end
    end
  end

endmodule

/* hdl/fdpa_queue.sv */
// ----------------------------------------------------------------------------
// fdpa_queue
// Short first-in first-out queue of products between front and back.
// ----------------------------------------------------------------------------
module fdpa_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  fdpa_pkg::prod_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output fdpa_pkg::prod_t pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fdpa_pkg::prod_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/fdpa_back.sv */
// ----------------------------------------------------------------------------
// fdpa_back
// Add each exact product into the running sum, round each sum once, emit on last.
// ----------------------------------------------------------------------------
`include "fp64_dot_product_accumulator_defines.svh"

module fdpa_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  fdpa_pkg::prod_t pop_data_i,
  fdpa_out_if.source      out_chan_o
);

  localparam logic [7:0] R_SAT = 8'd129;
  localparam logic [fdpa_pkg::EXP_W-1:0] D_MAX = fdpa_pkg::EXP_W'(fdpa_pkg::SIG_W - 1);

  fdpa_pkg::back_state_e state_q, state_d;
  logic [2:0]            step_q, step_d;
  logic [63:0]           acc_q, acc_d;
  logic                  out_valid_q, out_valid_d;
  logic [63:0]           out_bits_q;

  fdpa_pkg::sig_t pa_q, w_q;
  fdpa_pkg::exp_t pe_q, we_q, lsb_q;
  logic           ps_q, wsign_q, last_q, op_sub_q;
  logic [7:0]     r_q;
  logic [63:0]    res_q;

  // right shift with the lost bits folded into bit zero
  function automatic fdpa_pkg::sig_t shr_jam(fdpa_pkg::sig_t a,
                                             logic [fdpa_pkg::EXP_W-1:0] d);
    fdpa_pkg::sig_t r;
    logic           lost;
    if (d > D_MAX) begin
      r    = '0;
      r[0] = (a != '0);
    end else begin
      r    = a >> d[fdpa_pkg::SH_W-1:0];
      lost = |(a & ~({fdpa_pkg::SIG_W{1'b1}} << d[fdpa_pkg::SH_W-1:0]));
      r[0] = r[0] | lost;
    end
    return r;
  endfunction

  // running sum decode
  logic [10:0]    ce, ceu;
  logic [51:0]    cf;
  logic           sc, cz, ci, cn;
  logic [52:0]    cm;
  logic           is_special;
  logic [63:0]    spec_bits;

  always_comb begin
    ce  = acc_q[62:52];
    cf  = acc_q[51:0];
    sc  = acc_q[63];
    cz  = (ce == '0) && (cf == '0);
    ci  = (ce == '1) && (cf == '0);
    cn  = (ce == '1) && (cf != '0);
    ceu = (ce == '0) ? 11'd1 : ce;
    cm  = {ce != '0, cf};
    is_special = (pop_data_i.kind != fdpa_pkg::KIND_FIN) || cn || ci;
    if ((pop_data_i.kind == fdpa_pkg::KIND_NAN) || cn) begin
      spec_bits = fdpa_pkg::QNAN_BITS;
    end else if (pop_data_i.kind == fdpa_pkg::KIND_INF) begin
      spec_bits = (ci && (sc != pop_data_i.sign)) ? fdpa_pkg::QNAN_BITS
                : {pop_data_i.sign, fdpa_pkg::INF_BITS[62:0]};
    end else if (ci) begin
      spec_bits = acc_q;
    end else if (cz) begin
      spec_bits = (sc == pop_data_i.sign) ? {pop_data_i.sign, 63'd0} : 64'd0;
    end else begin
      spec_bits = acc_q;
    end
  end

  // alignment
  logic                       pa_big;
  logic [fdpa_pkg::EXP_W-1:0] shift_amt;
  fdpa_pkg::sig_t             sum_c;
  fdpa_pkg::norm_t            nstep;

  always_comb begin
    pa_big    = (pe_q > we_q) || ((pe_q == we_q) && (pa_q >= w_q));
    shift_amt = pa_big ? fdpa_pkg::EXP_W'(pe_q - we_q) : fdpa_pkg::EXP_W'(we_q - pe_q);
    sum_c     = op_sub_q ? (pa_q - w_q) : (pa_q + w_q);
    if (state_q == fdpa_pkg::B_CNORM) begin
      nstep = fdpa_pkg::norm_step(w_q, we_q, fdpa_pkg::SH_W'(step_q));
    end else if (step_q == 3'd0) begin
      // carry out of the add: move down one place, keep the lost bit
      nstep.sig = w_q[fdpa_pkg::TOP_POS+1] ? ((w_q >> 1) | {127'd0, w_q[0]}) : w_q;
      nstep.exp = w_q[fdpa_pkg::TOP_POS+1] ? (we_q + fdpa_pkg::exp_t'(1)) : we_q;
    end else begin
      nstep = fdpa_pkg::norm_step(w_q, we_q, fdpa_pkg::SH_W'(step_q - 3'd1));
    end
  end

  // rounding position and pack
  fdpa_pkg::exp_t  lsb_raw, lsb_c, r_full, be;
  logic [fdpa_pkg::SH_W-1:0] half_idx;
  logic            sat, half, sticky, inc;
  logic [53:0]     q54, q_inc;
  logic [63:0]     bits64, pack_bits;

  always_comb begin
    lsb_raw = we_q + fdpa_pkg::exp_t'(73);
    lsb_c   = (lsb_raw < fdpa_pkg::exp_t'(-1074)) ? fdpa_pkg::exp_t'(-1074) : lsb_raw;
    r_full  = lsb_c - we_q;

    sat      = (r_q == R_SAT);
    half_idx = fdpa_pkg::SH_W'(r_q - 8'd1);
    q54      = sat ? 54'd0 : 54'(w_q >> r_q);
    half     = sat ? 1'b0 : w_q[half_idx];
    sticky   = sat ? 1'b1 : |(w_q & ~({fdpa_pkg::SIG_W{1'b1}} << half_idx));
    inc      = half && (sticky || q54[0]);
    q_inc    = q54 + 54'(inc);
    be       = lsb_q + fdpa_pkg::exp_t'(1074);
    bits64   = {1'b0, be[10:0], 52'd0} + {10'd0, q_inc};
    if ((be > fdpa_pkg::exp_t'(2046)) || (bits64 >= fdpa_pkg::INF_BITS)) begin
      pack_bits = {wsign_q, fdpa_pkg::INF_BITS[62:0]};
    end else begin
      pack_bits = {wsign_q, bits64[62:0]};
    end
  end

  logic slot_free, done_fire, out_load;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fdpa_pkg::B_IDLE: begin
        if (pop_valid_i) begin
          if (is_special) begin
            state_d = fdpa_pkg::B_DONE;
          end else if (cz) begin
            state_d = fdpa_pkg::B_ROUND;
          end else if (cm[52]) begin
            state_d = fdpa_pkg::B_ALIGN;
          end else begin
            state_d = fdpa_pkg::B_CNORM;
          end
        end
      end
      fdpa_pkg::B_CNORM: begin
        if (step_q == 3'(fdpa_pkg::NORM_STEPS - 1)) state_d = fdpa_pkg::B_ALIGN;
      end
      fdpa_pkg::B_ALIGN: state_d = fdpa_pkg::B_ADD;
      fdpa_pkg::B_ADD: begin
        state_d = (sum_c == '0) ? fdpa_pkg::B_DONE : fdpa_pkg::B_NORM;
      end
      fdpa_pkg::B_NORM: begin
        if (step_q == 3'(fdpa_pkg::NORM_STEPS)) state_d = fdpa_pkg::B_ROUND;
      end
      fdpa_pkg::B_ROUND: state_d = fdpa_pkg::B_PACK;
      fdpa_pkg::B_PACK:  state_d = fdpa_pkg::B_DONE;
      fdpa_pkg::B_DONE: begin
        if (done_fire) state_d = fdpa_pkg::B_IDLE;
      end
      default: state_d = fdpa_pkg::B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    slot_free   = !out_valid_q || out_chan_o.ready;
    pop_ready_o = (state_q == fdpa_pkg::B_IDLE);
    done_fire   = (state_q == fdpa_pkg::B_DONE) && (!last_q || slot_free);
    out_load    = done_fire && last_q;
    step_d      = ((state_q == fdpa_pkg::B_CNORM) || (state_q == fdpa_pkg::B_NORM))
                ? step_q + 3'd1 : 3'd0;
    acc_d       = done_fire ? (last_q ? 64'd0 : res_q) : acc_q;
    out_valid_d = out_load ? 1'b1 : (out_chan_o.ready ? 1'b0 : out_valid_q);
  end

  assign out_chan_o.valid    = out_valid_q;
  assign out_chan_o.dot_bits = out_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdpa_pkg::B_IDLE;
      step_q      <= 3'd0;
      acc_q       <= 64'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_bits_q <= res_q;
    case (state_q)
      fdpa_pkg::B_IDLE: begin
        pa_q   <= pop_data_i.sig;
        pe_q   <= pop_data_i.exp;
        ps_q   <= pop_data_i.sign;
        last_q <= pop_data_i.last;
        res_q  <= spec_bits;
        if (cz) begin
          w_q     <= pop_data_i.sig;
          we_q    <= pop_data_i.exp;
          wsign_q <= pop_data_i.sign;
        end else begin
          w_q     <= {2'b00, cm, 73'd0};
          we_q    <= fdpa_pkg::exp_t'(ceu) - fdpa_pkg::exp_t'(1148);
          wsign_q <= sc;
        end
      end
      fdpa_pkg::B_CNORM, fdpa_pkg::B_NORM: begin
        w_q  <= nstep.sig;
        we_q <= nstep.exp;
      end
      fdpa_pkg::B_ALIGN: begin
        op_sub_q <= (ps_q != wsign_q);
        if (pa_big) begin
          w_q <= shr_jam(w_q, shift_amt);
        end else begin
          pa_q    <= w_q;
          pe_q    <= we_q;
          ps_q    <= wsign_q;
          w_q     <= shr_jam(pa_q, shift_amt);
        end
      end
      fdpa_pkg::B_ADD: begin
        w_q     <= sum_c;
        we_q    <= pe_q;
        wsign_q <= ps_q;
        res_q   <= 64'd0;
      end
      fdpa_pkg::B_ROUND: begin
        lsb_q <= lsb_c;
        r_q   <= (r_full > fdpa_pkg::exp_t'(R_SAT)) ? R_SAT : 8'(r_full);
      end
      fdpa_pkg::B_PACK: res_q <= pack_bits;
      default: ;
    endcase
  end

  `FDPA_ASSERT(a_c_normalized, (state_q == fdpa_pkg::B_ALIGN) |-> w_q[fdpa_pkg::TOP_POS], "running sum not normalized before align")
  `FDPA_NEVER(a_pack_top, (state_q == fdpa_pkg::B_PACK) && (!w_q[fdpa_pkg::TOP_POS] || (w_q[127:126] != 2'b00)), "sum not normalized at pack")
  `FDPA_ASSERT(a_clear_on_last, (done_fire && last_q) |=> (acc_q == 64'd0), "running sum not cleared after last")

endmodule

/* hdl/fp64_dot_product_accumulator.sv */
// ----------------------------------------------------------------------------
// fp64_dot_product_accumulator
// Binary64 dot product: fused multiply-add of each pair into a running sum.
// ----------------------------------------------------------------------------
//  channel     dir  payload                      notes
//  in_chan_i   in   x_bits[63:0] y_bits[63:0]    one element pair per item
//                   last                         last closes the vector
//  out_chan_o  out  dot_bits[63:0]               one item per closed vector
//
// The front end takes one pair per cycle unless held by a full queue: decode,
// four 32-bit partial products, product sum and seven normalize stages into a
// queue. The back end owns the running sum and takes one product at a time;
// its add, normalize and round sequence starts with a normalize pass for a
// subnormal running sum, is cut short if the sum cancels or the running sum
// is zero, and is skipped for NaN, infinity or zero products. That loop on
// the running sum sets the sustained rate. Reset clears the running sum to
// +0.0 and empties both pipelines and queue. A stalled output holds the back
// end only at a last item; the queue keeps the front end running meanwhile.
// ----------------------------------------------------------------------------
module fp64_dot_product_accumulator #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fdpa_in_if.sink    in_chan_i,
  fdpa_out_if.source out_chan_o
);

  // front to queue
  logic            fq_valid, fq_ready;
  fdpa_pkg::prod_t fq_data;

  // queue to back
  logic            qb_valid, qb_ready;
  fdpa_pkg::prod_t qb_data;

  // classify and multiply; advance unless a full queue refuses a product
  fdpa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_chan_i    (in_chan_i),
    .prod_valid_o (fq_valid),
    .prod_ready_i (fq_ready),
    .prod_o       (fq_data)
  );

  // hold exact products while the back end works through the sum
  fdpa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_data)
  );

  // accumulate in arrival order, round once per pair, drive the result item
  fdpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (qb_valid),
    .pop_ready_o (qb_ready),
    .pop_data_i  (qb_data),
    .out_chan_o  (out_chan_o)
  );

endmodule
